/* rtl/gtg_pkg.sv */
// Shared types, widths, constants and tables of the go-to-goal controller.
package gtg_pkg;

   // Field widths
   localparam int POS_W  = 16;   // Q6.10 position
   localparam int ANG_W  = 16;   // Q3.13 heading
   localparam int TOL_W  = 15;
   localparam int GAIN_W = 10;   // Q2.8 gain
   localparam int LIN_W  = 15;   // Q5.10 forward speed
   localparam int RATE_W = 16;   // Q4.12 turn rate

   // Internal widths
   localparam int DIFF_W = POS_W + 1;    // goal minus pose
   localparam int CORD_W = 20;           // CORDIC x/y, holds gain growth
   localparam int Z_W    = 20;           // angle accumulator, 2^-16 rad units
   localparam int SQ_W   = 35;           // dx^2 + dy^2 and root work registers
   localparam int DIST_W = 17;           // rounded root
   localparam int ERR_W  = 18;           // heading error in Q5.13
   localparam int MUL_W  = 18;           // shared multiplier operands
   localparam int PROD_W = 2 * MUL_W;

   // Iteration bounds
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SQRT_STEPS       = SQ_W / 2 + 1;   // one root bit per step
   localparam int ATAN_IW          = 5;              // table index bits (32 indexes, entries past 16 are zero)

   // Angle constants
   localparam int PI_Q13     = 25736;
   localparam int TWO_PI_Q13 = 51472;
   localparam int HALF_PI_Z  = 102944;

   // Rounding offsets
   localparam int ANG_RND   = 256;
   localparam int ANG_SHIFT = 9;
   localparam int LIN_RND   = 128;
   localparam int LIN_SHIFT = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_X    = 3'd0,
      CSR_GOAL_Y    = 3'd1,
      CSR_DIST_TOL  = 3'd2,
      CSR_ANGLE_TOL = 3'd3,
      CSR_ANG_GAIN  = 3'd4,
      CSR_LIN_GAIN  = 3'd5
   } csr_idx_type;

   localparam logic [TOL_W-1:0]  DIST_TOL_RST  = 15'd307;
   localparam logic [TOL_W-1:0]  ANGLE_TOL_RST = 15'd819;
   localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 10'd128;
   localparam logic [GAIN_W-1:0] LIN_GAIN_RST  = 10'd256;

   typedef struct packed {
      logic signed [POS_W-1:0] goal_x;
      logic signed [POS_W-1:0] goal_y;
      logic [TOL_W-1:0]        distance_tolerance;
      logic [TOL_W-1:0]        angle_tolerance;
      logic [GAIN_W-1:0]       angular_gain;
      logic [GAIN_W-1:0]       linear_gain;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture pose, form dx/dy
      logic sq_dx;      // multiplier: dx * dx
      logic sq_dy;      // multiplier: dy * dy, latch dx^2
      logic init;       // sum squares, pre-rotate CORDIC
      logic iter;       // one CORDIC step and one root step
      logic decide;     // wrap error, pick turn/drive/reached
      logic scale;      // multiplier: gain * error or gain * distance
      logic out_load;   // saturate into the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reached;
   } sts_type;

   // Total loop length: both iterative units share one counter
   function automatic int loop_len(input int steps);
      return (steps > SQRT_STEPS) ? steps : SQRT_STEPS;
   endfunction

   // atan(2^-i) in 2^-16 rad units
   function automatic logic [15:0] atan_lut(input logic [ATAN_IW-1:0] i);
      logic [15:0] v;
      case (i)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30386;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/gtg_ifs.sv */
// Channel interfaces: pose request, command response, register writes.
interface gtg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gtg_pkg::POS_W-1:0]    pose_x;
   logic signed [gtg_pkg::POS_W-1:0]    pose_y;
   logic signed [gtg_pkg::ANG_W-1:0]    pose_heading;

   modport source (output valid, pose_x, pose_y, pose_heading, input ready);
   modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface gtg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gtg_pkg::LIN_W-1:0]           linear_speed;
   logic signed [gtg_pkg::RATE_W-1:0]   angular_speed;
   logic                                goal_reached;

   modport source (output valid, linear_speed, angular_speed, goal_reached, input ready);
   modport sink   (input valid, linear_speed, angular_speed, goal_reached, output ready);
endinterface

interface gtg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gtg_pkg::CSR_IDX_W-1:0]       index;
   logic [gtg_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/go_to_goal_controller.sv */
// Go-to-goal controller top level: proportional turn/drive commands from pose.
// Steps per pose: load, square dx, square dy, init, the shared iterative loop,
//   decide, scale, result; once the goal has been reached, load goes straight to result.
// One pose in flight: a new pose is taken only after the result register is loaded;
//   the shared loop of the iterative root and the CORDIC sets the loop length.
// Reset: synchronous; gains, tolerances and goal return to defaults, flag clears.
module go_to_goal_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   gtg_req_if.sink      req_ch,
   gtg_rsp_if.source    rsp_ch,
   gtg_csr_if.sink      csr_ch
);

   localparam int ITER_W = $clog2(gtg_pkg::loop_len(CORDIC_STEPS));

   gtg_pkg::cfg_type    cfg;
   gtg_pkg::cmd_type    cmd;
   gtg_pkg::sts_type    sts;
   logic [ITER_W-1:0]   iter_idx;

   // Register file: a write shows in cfg from the next cycle on; always ready.
   gtg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // Sequencer: one item in flight; the result register frees the
   // input side, so a new pose is taken while a result still waits.
   gtg_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd),
      .iter_idx  (iter_idx)
   );

   // Datapath: one 18x18 multiplier shared by the squares and the gains,
   // a bit-per-step root and a vector-mode CORDIC running side by side.
   gtg_dp #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .pose_x        (req_ch.pose_x),
      .pose_y        (req_ch.pose_y),
      .pose_heading  (req_ch.pose_heading),
      .cmd           (cmd),
      .iter_idx      (iter_idx),
      .sts           (sts),
      .linear_speed  (rsp_ch.linear_speed),
      .angular_speed (rsp_ch.angular_speed),
      .goal_reached  (rsp_ch.goal_reached)
   );

endmodule

/* rtl/gtg_csr.sv */
// Configuration register file of the go-to-goal controller.
module gtg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_valid,
   output logic                              wr_ready,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]     wr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]    wr_data,
   output gtg_pkg::cfg_type                  cfg
);

   gtg_pkg::cfg_type cfg_ff;
   gtg_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            gtg_pkg::CSR_GOAL_X:    cfg_in.goal_x = wr_data;
            gtg_pkg::CSR_GOAL_Y:    cfg_in.goal_y = wr_data;
            gtg_pkg::CSR_DIST_TOL:  cfg_in.distance_tolerance = wr_data[gtg_pkg::TOL_W-1:0];
            gtg_pkg::CSR_ANGLE_TOL: cfg_in.angle_tolerance = wr_data[gtg_pkg::TOL_W-1:0];
            gtg_pkg::CSR_ANG_GAIN:  cfg_in.angular_gain = wr_data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::CSR_LIN_GAIN:  cfg_in.linear_gain = wr_data[gtg_pkg::GAIN_W-1:0];
            default: ;   // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_x             <= '0;
         cfg_ff.goal_y             <= '0;
         cfg_ff.distance_tolerance <= gtg_pkg::DIST_TOL_RST;
         cfg_ff.angle_tolerance    <= gtg_pkg::ANGLE_TOL_RST;
         cfg_ff.angular_gain       <= gtg_pkg::ANG_GAIN_RST;
         cfg_ff.linear_gain        <= gtg_pkg::LIN_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/gtg_ctrl.sv */
// Sequencer of the go-to-goal controller: handshakes and datapath commands.
module gtg_ctrl #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  gtg_pkg::sts_type         sts,
   output gtg_pkg::cmd_type         cmd,
   output logic [$clog2(gtg_pkg::loop_len(CORDIC_STEPS))-1:0] iter_idx
);

   localparam int LOOP_N = gtg_pkg::loop_len(CORDIC_STEPS);
   localparam int ITER_W = $clog2(LOOP_N);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_DX,
      ST_SQ_DY,
      ST_INIT,
      ST_ITER,
      ST_DECIDE,
      ST_SCALE,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign iter_idx  = iter_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               // already at the goal: straight to the result
               state_in = sts.reached ? ST_OUT : ST_SQ_DX;
            end
         end
         ST_SQ_DX: begin
            cmd.sq_dx = 1'b1;
            state_in  = ST_SQ_DY;
         end
         ST_SQ_DY: begin
            cmd.sq_dy = 1'b1;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            iter_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            iter_in  = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(LOOP_N - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/gtg_dp.sv */
// Datapath: squares, iterative root, vector-mode CORDIC, error wrap, gains.
module gtg_dp #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gtg_pkg::cfg_type                      cfg,
   input  logic signed [gtg_pkg::POS_W-1:0]      pose_x,
   input  logic signed [gtg_pkg::POS_W-1:0]      pose_y,
   input  logic signed [gtg_pkg::ANG_W-1:0]      pose_heading,
   input  gtg_pkg::cmd_type                      cmd,
   input  logic [$clog2(gtg_pkg::loop_len(CORDIC_STEPS))-1:0] iter_idx,
   output gtg_pkg::sts_type                      sts,
   output logic [gtg_pkg::LIN_W-1:0]             linear_speed,
   output logic signed [gtg_pkg::RATE_W-1:0]     angular_speed,
   output logic                                  goal_reached
);

   localparam int LOOP_N = gtg_pkg::loop_len(CORDIC_STEPS);
   localparam int ITER_W = $clog2(LOOP_N);
   localparam int LUT_IW = gtg_pkg::ATAN_IW;
   localparam int DIFF_W = gtg_pkg::DIFF_W;
   localparam int CORD_W = gtg_pkg::CORD_W;
   localparam int Z_W    = gtg_pkg::Z_W;
   localparam int SQ_W   = gtg_pkg::SQ_W;
   localparam int DIST_W = gtg_pkg::DIST_W;
   localparam int ERR_W  = gtg_pkg::ERR_W;
   localparam int MUL_W  = gtg_pkg::MUL_W;
   localparam int PROD_W = gtg_pkg::PROD_W;
   localparam int LIN_W  = gtg_pkg::LIN_W;
   localparam int RATE_W = gtg_pkg::RATE_W;

   localparam logic signed [ERR_W-1:0]  PI_E     = ERR_W'(gtg_pkg::PI_Q13);
   localparam logic signed [ERR_W-1:0]  TWO_PI_E = ERR_W'(gtg_pkg::TWO_PI_Q13);
   localparam logic signed [Z_W-1:0]    HALF_PI  = Z_W'(gtg_pkg::HALF_PI_Z);
   localparam logic signed [PROD_W-1:0] RATE_MAX = PROD_W'((1 << (RATE_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] RATE_MIN = -PROD_W'(1 << (RATE_W - 1));
   localparam logic signed [PROD_W-1:0] LIN_MAX  = PROD_W'((1 << LIN_W) - 1);

   typedef enum logic [1:0] {
      MODE_TURN,
      MODE_DRIVE,
      MODE_REACH
   } mode_type;

   // item registers
   logic signed [DIFF_W-1:0]      dx_ff, dy_ff;
   logic signed [gtg_pkg::ANG_W-1:0] heading_ff;
   logic                          zero_ff;   // pose sits on the goal
   logic                          reached_ff;

   // shared multiplier
   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic signed [PROD_W-1:0]      prod_ff;

   // integer root
   logic [SQ_W-1:0]               rem_ff, root_ff, bit_ff;
   logic [SQ_W-1:0]               trial;
   logic [SQ_W-1:0]               root_rnd;

   // CORDIC
   logic signed [CORD_W-1:0]      x_ff, y_ff, sx, sy;
   logic signed [Z_W-1:0]         z_ff, atan_z, z_rnd;

   // decision
   logic signed [ERR_W-1:0]       bearing, err_raw, err_w, aerr, atol;
   logic signed [ERR_W-1:0]       err_ff;
   logic [DIST_W-1:0]             dist_w, dist_ff;
   mode_type                      mode_w, mode_ff;

   // output scaling
   logic signed [PROD_W-1:0]      ang_full, lin_full;
   logic [LIN_W-1:0]              lin_sat;
   logic signed [RATE_W-1:0]      ang_sat;

   logic [LIN_W-1:0]              linear_ff;
   logic signed [RATE_W-1:0]      angular_ff;
   logic                          goal_ff;

   assign sts.reached   = reached_ff;
   assign linear_speed  = linear_ff;
   assign angular_speed = angular_ff;
   assign goal_reached  = goal_ff;

   // Multiplier operands per phase
   always_comb begin
      mul_a = MUL_W'(dx_ff);
      mul_b = MUL_W'(dx_ff);
      if (cmd.sq_dy) begin
         mul_a = MUL_W'(dy_ff);
         mul_b = MUL_W'(dy_ff);
      end else if (cmd.scale) begin
         if (mode_ff == MODE_TURN) begin
            mul_a = signed'(MUL_W'(cfg.angular_gain));
            mul_b = MUL_W'(err_ff);
         end else begin
            mul_a = signed'(MUL_W'(cfg.linear_gain));
            mul_b = signed'(MUL_W'(dist_ff));
         end
      end
   end

   // Root step and CORDIC step
   assign trial  = root_ff + bit_ff;
   assign sx     = x_ff >>> iter_idx;
   assign sy     = y_ff >>> iter_idx;
   assign atan_z = signed'(Z_W'(gtg_pkg::atan_lut(LUT_IW'(iter_idx))));

   // Decision logic
   assign root_rnd = (rem_ff > root_ff) ? root_ff + SQ_W'(1) : root_ff;
   assign dist_w   = root_rnd[DIST_W-1:0];
   assign z_rnd    = z_ff + Z_W'(4);
   assign bearing  = zero_ff ? '0 : ERR_W'(z_rnd >>> 3);
   assign err_raw  = bearing - ERR_W'(heading_ff);
   assign atol     = signed'(ERR_W'(cfg.angle_tolerance));

   always_comb begin
      if (err_raw > PI_E) begin
         err_w = err_raw - TWO_PI_E;
      end else if (err_raw < -PI_E) begin
         err_w = err_raw + TWO_PI_E;
      end else begin
         err_w = err_raw;
      end
      aerr = (err_w < 0) ? -err_w : err_w;
      if (aerr > atol) begin
         mode_w = MODE_TURN;
      end else if (dist_w > DIST_W'(cfg.distance_tolerance)) begin
         mode_w = MODE_DRIVE;
      end else begin
         mode_w = MODE_REACH;
      end
   end

   // Rounding and saturation of the scaled command
   assign ang_full = (prod_ff + PROD_W'(gtg_pkg::ANG_RND)) >>> gtg_pkg::ANG_SHIFT;
   assign lin_full = (prod_ff + PROD_W'(gtg_pkg::LIN_RND)) >>> gtg_pkg::LIN_SHIFT;

   always_comb begin
      if (ang_full > RATE_MAX) begin
         ang_sat = RATE_W'(RATE_MAX);
      end else if (ang_full < RATE_MIN) begin
         ang_sat = RATE_W'(RATE_MIN);
      end else begin
         ang_sat = RATE_W'(ang_full);
      end
      lin_sat = (lin_full > LIN_MAX) ? LIN_W'(LIN_MAX) : LIN_W'(lin_full);
   end

   // Sticky goal flag
   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= 1'b0;
      end else if (cmd.decide && (mode_w == MODE_REACH)) begin
         reached_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff      <= DIFF_W'(cfg.goal_x) - DIFF_W'(pose_x);
         dy_ff      <= DIFF_W'(cfg.goal_y) - DIFF_W'(pose_y);
         heading_ff <= pose_heading;
      end

      if (cmd.sq_dx || cmd.sq_dy || cmd.scale) begin
         prod_ff <= mul_a * mul_b;
      end

      if (cmd.sq_dy) begin
         rem_ff <= prod_ff[SQ_W-1:0];
      end else if (cmd.init) begin
         rem_ff  <= rem_ff + prod_ff[SQ_W-1:0];
         root_ff <= '0;
         bit_ff  <= SQ_W'(1) << (SQ_W - 1);
      end else if (cmd.iter && (iter_idx < ITER_W'(gtg_pkg::SQRT_STEPS))) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (cmd.init) begin
         zero_ff <= (dx_ff == '0) && (dy_ff == '0);
         if (dx_ff < 0) begin
            // left half plane: quarter turn toward the x axis first
            if (dy_ff >= 0) begin
               x_ff <= CORD_W'(dy_ff);
               y_ff <= -CORD_W'(dx_ff);
               z_ff <= HALF_PI;
            end else begin
               x_ff <= -CORD_W'(dy_ff);
               y_ff <= CORD_W'(dx_ff);
               z_ff <= -HALF_PI;
            end
         end else begin
            x_ff <= CORD_W'(dx_ff);
            y_ff <= CORD_W'(dy_ff);
            z_ff <= '0;
         end
      end else if (cmd.iter && (iter_idx < ITER_W'(CORDIC_STEPS))) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + sy;
            y_ff <= y_ff - sx;
            z_ff <= z_ff + atan_z;
         end else begin
            x_ff <= x_ff - sy;
            y_ff <= y_ff + sx;
            z_ff <= z_ff - atan_z;
         end
      end

      if (cmd.decide) begin
         err_ff  <= err_w;
         dist_ff <= dist_w;
         mode_ff <= mode_w;
      end

      if (cmd.out_load) begin
         goal_ff <= reached_ff;
         if (reached_ff) begin
            linear_ff  <= '0;
            angular_ff <= '0;
         end else if (mode_ff == MODE_TURN) begin
            linear_ff  <= '0;
            angular_ff <= ang_sat;
         end else begin
            linear_ff  <= lin_sat;
            angular_ff <= '0;
         end
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the go-to-goal controller against a bit-exact predictor.
module tb;

   localparam int     CLK_HALF_NS   = 5;
   localparam int     RESET_CYCLES  = 10;
   // idle time after the drain; gives the block room to finish
   localparam int     SETTLE_CYCLES = 40;
   localparam int     HOLD_CYCLES   = 400;
   localparam longint LIMIT_NS      = 5_000_000;

   // register indexes the block does not decode
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [gtg_pkg::POS_W-1:0] x;
      logic signed [gtg_pkg::POS_W-1:0] y;
      logic signed [gtg_pkg::ANG_W-1:0] heading;
   } pose_item_type;

   typedef struct {
      logic [gtg_pkg::LIN_W-1:0]         lin;
      logic signed [gtg_pkg::RATE_W-1:0] ang;
      logic                              reached;
   } cmd_item_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_type;

   // Predicts the command for each accepted pose and checks the block's output.
   class steer_checker_type;
      logic signed [gtg_pkg::POS_W-1:0] goal_x, goal_y;
      logic [gtg_pkg::TOL_W-1:0]        dist_tol, ang_tol;
      logic [gtg_pkg::GAIN_W-1:0]       ang_gain, lin_gain;
      bit                               at_goal;
      cmd_item_type                     pending_cmds[$];
      int                               atan_units[24];
      int unsigned mismatches, poses, checked, turns, drives, stops, reg_writes;

      function new();
         // atan(2^-i) in 2^-16 rad
         atan_units = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
         goal_x   = '0;
         goal_y   = '0;
         dist_tol = gtg_pkg::DIST_TOL_RST;
         ang_tol  = gtg_pkg::ANGLE_TOL_RST;
         ang_gain = gtg_pkg::ANG_GAIN_RST;
         lin_gain = gtg_pkg::LIN_GAIN_RST;
         at_goal  = 1'b0;
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      function void note_reg_write(logic [gtg_pkg::CSR_IDX_W-1:0] idx,
                                   logic [gtg_pkg::CSR_DATA_W-1:0] data);
         reg_writes++;
         case (idx)
            gtg_pkg::CSR_GOAL_X:    goal_x   = data;
            gtg_pkg::CSR_GOAL_Y:    goal_y   = data;
            gtg_pkg::CSR_DIST_TOL:  dist_tol = data[gtg_pkg::TOL_W-1:0];
            gtg_pkg::CSR_ANGLE_TOL: ang_tol  = data[gtg_pkg::TOL_W-1:0];
            gtg_pkg::CSR_ANG_GAIN:  ang_gain = data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::CSR_LIN_GAIN:  lin_gain = data[gtg_pkg::GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      // Vector-mode CORDIC bearing, Q3.13
      function longint bearing_of(longint dx, longint dy);
         longint x, y, z, nx, ny;
         if (dx == 0 && dy == 0) return 0;
         x = dx;
         y = dy;
         z = 0;
         if (x < 0) begin
            if (dy >= 0) begin
               x = dy;  y = -dx; z = gtg_pkg::HALF_PI_Z;
            end else begin
               x = -dy; y = dx;  z = -gtg_pkg::HALF_PI_Z;
            end
         end
         for (int i = 0; i < gtg_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z += atan_units[i];
            end else begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z -= atan_units[i];
            end
            x = nx;
            y = ny;
         end
         return (z + 4) >>> 3;
      endfunction

      // Square root rounded to nearest, exact
      function longint unsigned root_rounded(longint unsigned n);
         longint unsigned r, t;
         r = 0;
         for (int b = 17; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
         end
         if (n - r * r > r) r++;
         return r;
      endfunction

      function cmd_item_type predict_cmd(pose_item_type p, bit commit);
         cmd_item_type c;
         longint       dx, dy, err, aerr, dist_q10, v;
         bit           hit;
         c.lin = '0;
         c.ang = '0;
         hit   = at_goal;
         if (!at_goal) begin
            dx       = longint'(goal_x) - longint'(p.x);
            dy       = longint'(goal_y) - longint'(p.y);
            err      = bearing_of(dx, dy) - longint'(p.heading);
            dist_q10 = longint'(root_rounded(dx * dx + dy * dy));
            if (err > gtg_pkg::PI_Q13) err -= gtg_pkg::TWO_PI_Q13;
            else if (err < -gtg_pkg::PI_Q13) err += gtg_pkg::TWO_PI_Q13;
            aerr = (err < 0) ? -err : err;
            if (aerr > longint'(ang_tol)) begin
               v = (longint'(ang_gain) * err + gtg_pkg::ANG_RND) >>> gtg_pkg::ANG_SHIFT;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               c.ang = 16'(v);
               if (commit) turns++;
            end else if (dist_q10 > longint'(dist_tol)) begin
               v = (longint'(lin_gain) * dist_q10 + gtg_pkg::LIN_RND) >>> gtg_pkg::LIN_SHIFT;
               if (v > 32767) v = 32767;
               c.lin = 15'(v);
               if (commit) drives++;
            end else begin
               hit = 1'b1;
            end
         end
         if (commit && hit) stops++;
         if (commit) at_goal = hit;
         c.reached = hit;
         return c;
      endfunction

      function void note_pose(pose_item_type p);
         poses++;
         pending_cmds.push_back(predict_cmd(p, 1'b1));
      endfunction

      function bit would_reach(pose_item_type p);
         cmd_item_type c;
         if (at_goal) return 1'b0;
         c = predict_cmd(p, 1'b0);
         return c.reached;
      endfunction

      task check_cmd(logic [gtg_pkg::LIN_W-1:0] lin, logic signed [gtg_pkg::RATE_W-1:0] ang,
                     logic reached);
         cmd_item_type e;
         if (pending_cmds.size() == 0) begin
            report($sformatf("unexpected command lin=%0d ang=%0d reached=%0b",
                             lin, ang, reached));
            return;
         end
         e = pending_cmds.pop_front();
         checked++;
         if (lin !== e.lin)
            report($sformatf("command %0d: linear_speed %0d, expected %0d", checked, lin, e.lin));
         if (ang !== e.ang)
            report($sformatf("command %0d: angular_speed %0d, expected %0d", checked, ang, e.ang));
         if (reached !== e.reached)
            report($sformatf("command %0d: goal_reached %0b, expected %0b",
                             checked, reached, e.reached));
      endtask
   endclass

   logic              clock;
   logic              reset;
   steer_checker_type sb;
   bit                hold_request;    // main sequence asks the receiver for a long hold-off
   int unsigned       long_holds;
   int unsigned       settings_used;

   gtg_req_if req();
   gtg_rsp_if rsp();
   gtg_csr_if csr();

   go_to_goal_controller DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF_NS clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Pose items
   // ---------------------------------------------------------------
   function automatic pose_item_type mk(int x, int y, int h);
      pose_item_type p;
      p.x       = 16'(x);
      p.y       = 16'(y);
      p.heading = 16'(h);
      return p;
   endfunction

   // Pose at (x, y) with heading = bearing to goal + off, so the heading error is -off
   function automatic pose_item_type aim(int x, int y, int off);
      pose_item_type p;
      p = mk(x, y, 0);
      p.heading = 16'(sb.bearing_of(longint'(sb.goal_x) - longint'(p.x),
                                    longint'(sb.goal_y) - longint'(p.y)) + off);
      return p;
   endfunction

   // The reached flag is sticky and reset comes only once, so every phase but the
   // last keeps the goal out of reach. Putting the pose half the range away in x
   // makes the distance at least 32768, above any tolerance.
   function automatic pose_item_type keep_off_goal(pose_item_type p);
      if (sb.would_reach(p)) p.x = sb.goal_x ^ 16'h8000;
      return p;
   endfunction

   function automatic pose_item_type make_pose(bit may_reach);
      pose_item_type p;
      int            kind, span, w, d;
      kind = $urandom_range(0, 99);
      span = $urandom_range(0, 15);
      p.x       = 16'($urandom);
      p.y       = 16'($urandom);
      p.heading = 16'($urandom);
      if (kind >= 30 && kind < 85) begin
         // close to the goal, offset of random magnitude (span 15 reaches anywhere)
         p.x = sb.goal_x + 16'(int'($urandom) >>> (31 - span));
         p.y = sb.goal_y + 16'(int'($urandom) >>> (31 - span));
      end
      if (kind >= 50 && kind < 85) begin
         // pointed at the goal within about the tolerance: drive vs. turn boundary
         w = int'(sb.ang_tol) + 64;
         d = int'($urandom_range(0, 2 * w)) - w;
         p.heading = 16'(sb.bearing_of(longint'(sb.goal_x) - longint'(p.x),
                                       longint'(sb.goal_y) - longint'(p.y)) + d);
      end else if (kind >= 85) begin
         // headings around +/-pi, some beyond it
         p.heading = 16'(($urandom_range(0, 1) ? gtg_pkg::PI_Q13 : -gtg_pkg::PI_Q13)
                         + int'($urandom_range(0, 16384)) - 8192);
      end
      if (!may_reach) p = keep_off_goal(p);
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic send_pose(pose_item_type p);
      req.valid        <= 1'b1;
      req.pose_x       <= p.x;
      req.pose_y       <= p.y;
      req.pose_heading <= p.heading;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_pose(p);
   endtask

   // Bursts of back-to-back items separated by random gaps (sometimes none)
   task automatic send_random(int count, bit may_reach);
      int left, burst, gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_pose(make_pose(may_reach));
         left -= burst;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (left > 0 && gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock); while (sb.pending_cmds.size() != 0);
   endtask

   // Idle point for register writes: all commands back, pipeline quiet
   task automatic drain_and_settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [gtg_pkg::CSR_IDX_W-1:0] idx,
                            logic [gtg_pkg::CSR_DATA_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.note_reg_write(idx, value);
   endtask

   task automatic program_all(int gx, int gy, int dtol, int atol, int again, int lgain);
      write_reg(gtg_pkg::CSR_GOAL_X,    16'(gx));
      write_reg(gtg_pkg::CSR_GOAL_Y,    16'(gy));
      write_reg(gtg_pkg::CSR_DIST_TOL,  16'(dtol));
      write_reg(gtg_pkg::CSR_ANGLE_TOL, 16'(atol));
      write_reg(gtg_pkg::CSR_ANG_GAIN,  16'(again));
      write_reg(gtg_pkg::CSR_LIN_GAIN,  16'(lgain));
      csr.valid <= 1'b0;
      settings_used++;
   endtask

   // Directed items under the reset settings: goal at origin, tolerances 0.3 / 0.1
   task automatic run_directed();
      send_pose(keep_off_goal(mk(-32768, -32768, 0)));      // corner, turn
      send_pose(keep_off_goal(mk(32767, 32767, -32768)));   // heading minimum
      send_pose(keep_off_goal(mk(32767, -32768, 32767)));   // heading maximum, past pi
      send_pose(keep_off_goal(mk(-32768, 32767, -25736)));
      send_pose(keep_off_goal(mk(0, 0, 8192)));             // on the goal: bearing zero
      send_pose(keep_off_goal(mk(0, 0, -8192)));
      send_pose(keep_off_goal(mk(0, 0, 32767)));
      send_pose(keep_off_goal(mk(1, 0, 0)));                // goal straight behind
      send_pose(keep_off_goal(mk(0, 1, 0)));
      send_pose(keep_off_goal(mk(-10240, 0, 0)));           // straight ahead, drive
      send_pose(keep_off_goal(aim(0, -10240, 0)));
      send_pose(keep_off_goal(aim(10240, 0, 0)));           // pre-rotation, dy >= 0
      send_pose(keep_off_goal(aim(10240, 10240, 0)));       // pre-rotation, dy < 0
      send_pose(keep_off_goal(mk(10240, -1, -25736)));      // error above pi wraps down
      send_pose(keep_off_goal(mk(10240, 1, 25736)));        // error below -pi wraps up
      send_pose(keep_off_goal(aim(-5000, 3000, -819)));     // error exactly at tolerance
      send_pose(keep_off_goal(aim(-5000, 3000, -820)));     // one past it
      send_pose(keep_off_goal(aim(-5000, 3000, 819)));
      send_pose(keep_off_goal(aim(-5000, 3000, 820)));
      send_pose(keep_off_goal(mk(-308, 0, 0)));             // one past distance tolerance
      send_pose(keep_off_goal(aim(218, 218, 0)));
   endtask

   // ---------------------------------------------------------------
   // Receiver: stall pattern of its own, plus a long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      rx_style_type style;
      int           seg, period, cnt, hold_left;
      rsp.ready <= 1'b0;
      hold_left = 0;
      forever begin
         style  = rx_style_type'($urandom_range(0, 3));
         seg    = $urandom_range(16, 160);
         period = $urandom_range(2, 9);
         for (cnt = 0; cnt < seg; cnt++) begin
            @(posedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               hold_left    = HOLD_CYCLES;
               long_holds++;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp.ready <= 1'b0;
            end else begin
               case (style)
                  RX_OPEN:   rsp.ready <= 1'b1;
                  RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
                  default:   rsp.ready <= ((cnt % period) != 0);
               endcase
            end
         end
      end
   end

   // Every accepted command is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_cmd(rsp.linear_speed, rsp.angular_speed, rsp.goal_reached);
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      sb = new();
      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.pose_x       <= '0;
      req.pose_y       <= '0;
      req.pose_heading <= '0;
      csr.valid        <= 1'b0;
      csr.index        <= '0;
      csr.data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      run_directed();
      send_random(120, 1'b0);
      drain_and_settle();

      // zero tolerances, full-scale gains: saturation; output held off so the
      // block backs up and stalls its input while items keep coming
      program_all($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0, 1023, 1023);
      hold_request = 1'b1;
      send_random(120, 1'b0);
      drain_and_settle();

      // goal at opposite corners, widest tolerances, zero gains; the sender
      // stops midway until every command is back
      program_all(-32768, 32767, 32767, 32767, 0, 0);
      send_random(50, 1'b0);
      drain();
      send_random(50, 1'b0);
      drain_and_settle();

      // moderate random settings
      program_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
      send_random(120, 1'b0);
      drain_and_settle();

      // zero angle tolerance: nearly every tick turns, at full gain
      program_all(32767, -32768, 32767, 0, 1023, 1023);
      send_random(120, 1'b0);
      drain_and_settle();

      // stray writes: undecoded indexes and bits above the tolerance and gain fields' widths
      write_reg(CSR_SPARE_6,            16'($urandom));
      write_reg(gtg_pkg::CSR_DIST_TOL,  {1'b1, 15'($urandom_range(0, 2047))});
      write_reg(gtg_pkg::CSR_ANG_GAIN,  {6'($urandom), 10'($urandom)});
      write_reg(gtg_pkg::CSR_LIN_GAIN,  {6'($urandom), 10'($urandom)});
      write_reg(gtg_pkg::CSR_ANGLE_TOL, {1'b1, 15'($urandom_range(0, 4095))});
      write_reg(CSR_SPARE_7,            16'($urandom));
      write_reg(gtg_pkg::CSR_GOAL_X,    16'($urandom));
      csr.valid <= 1'b0;
      settings_used++;
      send_random(120, 1'b0);
      drain_and_settle();

      // last setting: park on the goal, then the flag must hold with zero speeds
      program_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 1023), $urandom_range(0, 4095),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
      send_random(100, 1'b0);
      @(posedge clock);
      send_pose(mk(sb.goal_x, sb.goal_y, 0));
      send_random(15, 1'b1);
      drain_and_settle();

      if (sb.pending_cmds.size() != 0)
         sb.report($sformatf("%0d commands never arrived", sb.pending_cmds.size()));
      $display("Covered %0d pose ticks and %0d commands over %0d settings (%0d writes).",
               sb.poses, sb.checked, settings_used, sb.reg_writes);
      $display("Commands: %0d turn, %0d drive, %0d at goal; long output hold-offs: %0d.",
               sb.turns, sb.drives, sb.stops, long_holds);
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("Timeout at %0t with %0d commands outstanding", $time, sb.pending_cmds.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
